// ===== sv/register_file_alu_executor_defines.svh =====
// assertion macros used by the executor module
`ifndef REGISTER_FILE_ALU_EXECUTOR_DEFINES_SVH
`define REGISTER_FILE_ALU_EXECUTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rfa_pkg.sv =====
`timescale 1ns / 1ps

package rfa_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_EXEC  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // alu opcodes
    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_MOV     = 4'd1,
        OP_XOR     = 4'd2,
        OP_OR      = 4'd3,
        OP_AND     = 4'd4,
        OP_LSL     = 4'd5,
        OP_LSR     = 4'd6,
        OP_LT      = 4'd7,
        OP_ADD     = 4'd8,
        OP_SUB     = 4'd9,
        OP_MUL     = 4'd10,
        OP_EQ      = 4'd11,
        OP_DIV     = 4'd12,
        OP_MOD     = 4'd13,
        OP_CMOV    = 4'd14,
        OP_INVALID = 4'd15
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_OP   = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    // sequencer to alu
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    // alu to sequencer
    typedef struct packed {
        logic    done;
        t_status status;
    } t_alu_rsp;

endpackage

// ===== sv/register_file_alu_executor.sv =====
`timescale 1ns / 1ps
`include "register_file_alu_executor_defines.svh"

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// item in   | start high, busy low | i_kind i_opcode i_dest_index i_[abc]_is_reg
//           |                      | i_[abc]_reg i_[abc]_imm
// result    | o_valid, one cycle   | o_value o_status
//
// write item and unknown kind: result registered in the cycle after accept, busy stays low
// read item: busy through states FA and FB (one register file read port, registered data)
// execute: busy through states FA, FB, FC, FZ and ALU; three operand reads share one port,
// then mul, div and mod (nonzero divisor) wait in ALU on the bit-per-cycle shared alu loop
// reset: synchronous, active low; register contents are undefined until written
// the receiver cannot stall; every result is strobed for exactly one cycle

module register_file_alu_executor #(
    parameter int unsigned NUM_REGS   = 256,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_dest_index,
    input  logic        i_a_is_reg,
    input  logic [7:0]  i_a_reg,
    input  logic [31:0] i_a_imm,
    input  logic        i_b_is_reg,
    input  logic [7:0]  i_b_reg,
    input  logic [31:0] i_b_imm,
    input  logic        i_c_is_reg,
    input  logic [7:0]  i_c_reg,
    input  logic [31:0] i_c_imm,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    import rfa_pkg::*;

    localparam int unsigned WW = WORD_WIDTH;
    localparam int unsigned AW = $clog2(NUM_REGS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FA   = 6'b000010,
        S_FB   = 6'b000100,
        S_FC   = 6'b001000,
        S_FZ   = 6'b010000,
        S_ALU  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // latched item
    t_kind       r_kind;
    t_op         r_op;
    logic [7:0]  r_dest;
    logic        r_a_is_reg, r_b_is_reg, r_c_is_reg;
    logic [7:0]  r_a_reg, r_b_reg, r_c_reg;
    logic [31:0] r_a_imm, r_b_imm, r_c_imm;
    logic [WW-1:0] r_x, r_y;

    // result register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_value, n_out_value;
    t_status     r_out_status, n_out_status;

    logic          w_accept;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [WW-1:0] mem_wdata, mem_rdata;

    logic          w_sel_is_reg;
    logic [7:0]    w_sel_idx;
    logic [31:0]   w_sel_imm;
    logic [WW-1:0] w_opnd;

    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;
    logic [WW-1:0] alu_result;

    function automatic logic f_in_range(input logic [7:0] idx);
        return 32'(idx) < 32'(NUM_REGS);
    endfunction

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    rfa_regfile #(
        .DEPTH (NUM_REGS),
        .WIDTH (WW),
        .AW    (AW)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rfa_alu #(
        .WORD_WIDTH (WW)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_x      (r_x),
        .i_y      (r_y),
        .i_z      (w_opnd),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    // operand read address, one per fetch state
    always_comb begin
        mem_re = 1'b0;
        case (r_state)
            S_FA: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_a_reg);
            end
            S_FB: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_b_reg);
            end
            S_FC: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_c_reg);
            end
            default: begin
                mem_raddr = AW'(r_a_reg);
            end
        endcase
    end

    // operand capture: register data arrives in the state after its read
    always_comb begin
        case (r_state)
            S_FC: begin
                w_sel_is_reg = r_b_is_reg;
                w_sel_idx    = r_b_reg;
                w_sel_imm    = r_b_imm;
            end
            S_FZ: begin
                w_sel_is_reg = r_c_is_reg;
                w_sel_idx    = r_c_reg;
                w_sel_imm    = r_c_imm;
            end
            default: begin
                w_sel_is_reg = r_a_is_reg;
                w_sel_idx    = r_a_reg;
                w_sel_imm    = r_a_imm;
            end
        endcase
        if (w_sel_is_reg) begin
            w_opnd = f_in_range(w_sel_idx) ? mem_rdata : '0;
        end else begin
            w_opnd = WW'(w_sel_imm);
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_out_valid   = 1'b0;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        mem_we        = 1'b0;
        mem_waddr     = AW'(r_dest);
        mem_wdata     = alu_result;
        alu_req.start = 1'b0;
        alu_req.op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_kind'(i_kind))
                        KIND_WRITE: begin
                            mem_we       = f_in_range(i_dest_index);
                            mem_waddr    = AW'(i_dest_index);
                            mem_wdata    = WW'(i_a_imm);
                            n_out_valid  = 1'b1;
                            n_out_value  = 32'(WW'(i_a_imm));
                            n_out_status = ST_OK;
                        end
                        KIND_EXEC, KIND_READ: begin
                            n_state = S_FA;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_FA: begin
                n_state = S_FB;
            end
            S_FB: begin
                if (r_kind == KIND_READ) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = 32'(w_opnd);
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_FC;
                end
            end
            S_FC: begin
                n_state = S_FZ;
            end
            S_FZ: begin
                alu_req.start = 1'b1;
                n_state       = S_ALU;
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    mem_we       = (r_op != OP_NOP) && (r_op != OP_INVALID) &&
                                   f_in_range(r_dest);
                    n_out_valid  = 1'b1;
                    n_out_value  = 32'(alu_result);
                    n_out_status = alu_rsp.status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        if (w_accept) begin
            r_kind     <= t_kind'(i_kind);
            r_op       <= t_op'(i_opcode);
            r_dest     <= i_dest_index;
            // a read item fetches its register through the first operand slot
            r_a_is_reg <= (t_kind'(i_kind) == KIND_READ) ? 1'b1 : i_a_is_reg;
            r_a_reg    <= (t_kind'(i_kind) == KIND_READ) ? i_dest_index : i_a_reg;
            r_a_imm    <= i_a_imm;
            r_b_is_reg <= i_b_is_reg;
            r_b_reg    <= i_b_reg;
            r_b_imm    <= i_b_imm;
            r_c_is_reg <= i_c_is_reg;
            r_c_reg    <= i_c_reg;
            r_c_imm    <= i_c_imm;
        end
        if (r_state == S_FB) begin
            r_x <= w_opnd;
        end
        if (r_state == S_FC) begin
            r_y <= w_opnd;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    // checks
    `RFA_ASSERT_NXT(a_accept_moves, i_clk, i_rst_n, i_rst_n && start && !busy, o_valid || r_state == S_FA, "accepted item neither answered nor fetched")
    `RFA_ASSERT_IMP(a_done_in_alu, i_clk, i_rst_n, alu_rsp.done, r_state == S_ALU, "alu done outside its wait state")
    `RFA_ASSERT_IMP(a_div_zero_value, i_clk, i_rst_n, o_valid && o_status == ST_DIV_ZERO, o_value == '0, "division by zero must return zero")
    `RFA_ASSERT_IMP(a_alu_entry, i_clk, i_rst_n, r_state == S_ALU, $past(r_state) == S_FZ || $past(r_state) == S_ALU, "alu wait entered without a start")

endmodule

// ===== sv/rfa_regfile.sv =====
`timescale 1ns / 1ps

module rfa_regfile #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // single registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rfa_alu.sv =====
`timescale 1ns / 1ps

module rfa_alu #(
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rfa_pkg::t_alu_req     i_req,
    input  logic [WORD_WIDTH-1:0] i_x,
    input  logic [WORD_WIDTH-1:0] i_y,
    input  logic [WORD_WIDTH-1:0] i_z,
    output rfa_pkg::t_alu_rsp     o_rsp,
    output logic [WORD_WIDTH-1:0] o_result
);

    import rfa_pkg::*;

    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);
    localparam int unsigned SW = $clog2(W);
    localparam logic [W-1:0] SHIFT_LIMIT = W'(W);

    logic          r_done;
    logic          r_run;
    logic [CW-1:0] r_cnt;
    t_status       r_status;
    t_op           r_op;
    logic [W-1:0]  r_res;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_q;

    logic [W-1:0]  w_simple;
    logic          w_is_div;
    logic [W:0]    w_shifted;
    logic [W+1:0]  w_addend;
    logic [W+1:0]  w_sum;
    logic          w_ge;
    logic          w_iter_start;

    // combinational operations, latched into r_res at start
    always_comb begin
        case (i_req.op)
            OP_MOV:  w_simple = i_x;
            OP_XOR:  w_simple = i_x ^ i_y;
            OP_OR:   w_simple = i_x | i_y;
            OP_AND:  w_simple = i_x & i_y;
            OP_LSL:  w_simple = (i_y >= SHIFT_LIMIT) ? '0 : (i_x << i_y[SW-1:0]);
            OP_LSR:  w_simple = (i_y >= SHIFT_LIMIT) ? '0 : (i_x >> i_y[SW-1:0]);
            OP_LT:   w_simple = {{(W-1){1'b0}}, (i_x < i_y)};
            OP_ADD:  w_simple = i_x + i_y;
            OP_SUB:  w_simple = i_x - i_y;
            OP_EQ:   w_simple = {{(W-1){1'b0}}, (i_x == i_y)};
            OP_CMOV: w_simple = (i_x != '0) ? i_y : i_z;
            default: w_simple = '0;
        endcase
    end

    // shared shift-add / shift-subtract step, one bit per cycle
    assign w_is_div  = (r_op == OP_DIV) || (r_op == OP_MOD);
    assign w_shifted = w_is_div ? {r_acc, r_q[W-1]} : {r_acc, 1'b0};
    assign w_addend  = w_is_div ? ~{2'b00, i_y} : {2'b00, (r_q[W-1] ? i_x : '0)};
    assign w_sum     = {1'b0, w_shifted} + w_addend + (W+2)'(w_is_div);
    assign w_ge      = ~w_sum[W+1];

    assign w_iter_start = i_req.start &&
        ((i_req.op == OP_MUL) ||
         (((i_req.op == OP_DIV) || (i_req.op == OP_MOD)) && (i_y != '0)));

    // control: run flag, bit counter, done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_run  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= w_iter_start;
                r_done <= !w_iter_start;
                r_cnt  <= CW'(W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op     <= i_req.op;
            r_res    <= w_simple;
            r_acc    <= '0;
            r_status <= ST_OK;
            case (i_req.op)
                OP_MUL: begin
                    r_q <= i_y;
                end
                OP_DIV, OP_MOD: begin
                    r_q <= (i_y == '0) ? '0 : i_x;
                    if (i_y == '0) begin
                        r_status <= ST_DIV_ZERO;
                    end
                end
                OP_INVALID: begin
                    r_q      <= '0;
                    r_status <= ST_BAD_OP;
                end
                default: begin
                    r_q <= '0;
                end
            endcase
        end else if (r_run) begin
            if (w_is_div) begin
                r_acc <= w_ge ? w_sum[W-1:0] : w_shifted[W-1:0];
                r_q   <= {r_q[W-2:0], w_ge};
            end else begin
                r_acc <= w_sum[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    // result select
    always_comb begin
        case (r_op)
            OP_MUL:  o_result = r_acc;
            OP_DIV:  o_result = r_q;
            OP_MOD:  o_result = r_acc;
            default: o_result = r_res;
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.status = r_status;

endmodule

// ===== bench/tb_register_file_alu_executor.sv =====
`timescale 1ns / 1ps

module tb_register_file_alu_executor;
    import rfa_pkg::*;

    localparam int unsigned WORD_WIDTH = 32;

    // one input item as the driver sees it
    typedef struct {
        t_kind       kind;
        t_op         opcode;
        logic [7:0]  dest_index;
        logic        a_is_reg;
        logic [7:0]  a_reg;
        logic [31:0] a_imm;
        logic        b_is_reg;
        logic [7:0]  b_reg;
        logic [31:0] b_imm;
        logic        c_is_reg;
        logic [7:0]  c_reg;
        logic [31:0] c_imm;
    } t_rf_item;

    // one result item
    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_rf_result;

    // shadow register file, alu and queue of results still to come
    class alu_scoreboard;
        logic [31:0] regs [256];
        bit          written [256];
        int unsigned written_list [$];
        t_rf_result  pending_results [$];
        int unsigned errors;

        function void store(logic [7:0] idx, logic [31:0] v);
            regs[idx] = v;
            if (!written[idx]) begin
                written[idx] = 1'b1;
                written_list.push_back(32'(idx));
            end
        endfunction

        function logic [31:0] operand(logic is_reg, logic [7:0] idx, logic [31:0] imm);
            return is_reg ? regs[idx] : imm;
        endfunction

        // work out what an accepted item returns and apply its register write
        function void note_item(t_rf_item it);
            t_rf_result  res;
            logic [31:0] x;
            logic [31:0] y;
            logic [31:0] z;
            logic [31:0] r;
            bit          wr;
            res.value  = '0;
            res.status = ST_OK;
            case (it.kind)
                KIND_WRITE: begin
                    res.value = it.a_imm;
                    store(it.dest_index, it.a_imm);
                end
                KIND_READ: res.value = regs[it.dest_index];
                KIND_EXEC: begin
                    x  = operand(it.a_is_reg, it.a_reg, it.a_imm);
                    y  = operand(it.b_is_reg, it.b_reg, it.b_imm);
                    z  = operand(it.c_is_reg, it.c_reg, it.c_imm);
                    r  = '0;
                    wr = 1'b1;
                    case (it.opcode)
                        OP_NOP:  wr = 1'b0;
                        OP_MOV:  r = x;
                        OP_XOR:  r = x ^ y;
                        OP_OR:   r = x | y;
                        OP_AND:  r = x & y;
                        OP_LSL:  r = (y >= WORD_WIDTH) ? '0 : x << y;
                        OP_LSR:  r = (y >= WORD_WIDTH) ? '0 : x >> y;
                        OP_LT:   r = (x < y) ? 32'd1 : 32'd0;
                        OP_ADD:  r = x + y;
                        OP_SUB:  r = x - y;
                        OP_MUL:  r = x * y;
                        OP_EQ:   r = (x == y) ? 32'd1 : 32'd0;
                        OP_DIV: begin
                            if (y == 0) res.status = ST_DIV_ZERO;
                            else r = x / y;
                        end
                        OP_MOD: begin
                            if (y == 0) res.status = ST_DIV_ZERO;
                            else r = x % y;
                        end
                        OP_CMOV: r = (x != 0) ? y : z;
                        default: begin
                            wr         = 1'b0;
                            res.status = ST_BAD_OP;
                        end
                    endcase
                    if (wr) begin
                        store(it.dest_index, r);
                        res.value = r;
                    end
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        // compare a strobed result with the oldest one due
        function void check_result(logic [31:0] value, logic [1:0] status);
            t_rf_result res;
            if (pending_results.size() == 0) begin
                $error("unexpected result: value %h status %0d", value, status);
                errors++;
                return;
            end
            res = pending_results.pop_front();
            if (value !== res.value) begin
                $error("value mismatch: expected %h, actual %h", res.value, value);
                errors++;
            end
            if (status !== res.status) begin
                $error("status mismatch: expected %0d, actual %0d", res.status, status);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [1:0]  i_kind       = '0;
    logic [3:0]  i_opcode     = '0;
    logic [7:0]  i_dest_index = '0;
    logic        i_a_is_reg   = 1'b0;
    logic [7:0]  i_a_reg      = '0;
    logic [31:0] i_a_imm      = '0;
    logic        i_b_is_reg   = 1'b0;
    logic [7:0]  i_b_reg      = '0;
    logic [31:0] i_b_imm      = '0;
    logic        i_c_is_reg   = 1'b0;
    logic [7:0]  i_c_reg      = '0;
    logic [31:0] i_c_imm      = '0;
    logic        o_valid;
    logic [31:0] o_value;
    logic [1:0]  o_status;

    alu_scoreboard sb;

    register_file_alu_executor dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_opcode     (i_opcode),
        .i_dest_index (i_dest_index),
        .i_a_is_reg   (i_a_is_reg),
        .i_a_reg      (i_a_reg),
        .i_a_imm      (i_a_imm),
        .i_b_is_reg   (i_b_is_reg),
        .i_b_reg      (i_b_reg),
        .i_b_imm      (i_b_imm),
        .i_c_is_reg   (i_c_is_reg),
        .i_c_reg      (i_c_reg),
        .i_c_imm      (i_c_imm),
        .o_valid      (o_valid),
        .o_value      (o_value),
        .o_status     (o_status)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_result(o_value, o_status);
    end

    // item builders
    function automatic t_rf_item write_op(logic [7:0] idx, logic [31:0] data);
        t_rf_item it = '{KIND_WRITE, OP_NOP, idx, 1'b0, '0, data, 1'b0, '0, '0, 1'b0, '0, '0};
        return it;
    endfunction

    function automatic t_rf_item read_op(logic [7:0] idx);
        t_rf_item it = '{KIND_READ, OP_NOP, idx, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0, '0, '0};
        return it;
    endfunction

    function automatic t_rf_item exec_op(t_op op, logic [7:0] dst,
                                         logic ais, logic [7:0] areg, logic [31:0] aimm,
                                         logic bis, logic [7:0] breg, logic [31:0] bimm,
                                         logic cis, logic [7:0] creg, logic [31:0] cimm);
        t_rf_item it = '{KIND_EXEC, op, dst, ais, areg, aimm, bis, breg, bimm,
                         cis, creg, cimm};
        return it;
    endfunction

    // random data with extremes and shift-sized values mixed in
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 40);
            3:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // only registers already loaded are ever read
    function automatic logic [7:0] pick_written();
        return 8'(sb.written_list[$urandom_range(0, sb.written_list.size() - 1)]);
    endfunction

    // destinations: mostly a small pool, otherwise any register
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_rf_item random_item();
        t_rf_item    it;
        int unsigned sel;
        sel           = $urandom_range(0, 99);
        it.kind       = sel < 25 ? KIND_WRITE : sel < 80 ? KIND_EXEC :
                        sel < 95 ? KIND_READ : KIND_NONE;
        it.opcode     = t_op'($urandom_range(0, 15));
        it.dest_index = (it.kind == KIND_READ) ? pick_written() : pick_index();
        it.a_is_reg   = 1'($urandom_range(0, 1));
        it.a_reg      = it.a_is_reg ? pick_written() : 8'($urandom);
        it.a_imm      = random_word();
        it.b_is_reg   = 1'($urandom_range(0, 1));
        it.b_reg      = it.b_is_reg ? pick_written() : 8'($urandom);
        it.b_imm      = random_word();
        it.c_is_reg   = 1'($urandom_range(0, 1));
        it.c_reg      = it.c_is_reg ? pick_written() : 8'($urandom);
        it.c_imm      = random_word();
        return it;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned random_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // offer an item and hold it until the block takes it
    task automatic send_item(t_rf_item it);
        start        <= 1'b1;
        i_kind       <= it.kind;
        i_opcode     <= it.opcode;
        i_dest_index <= it.dest_index;
        i_a_is_reg   <= it.a_is_reg;
        i_a_reg      <= it.a_reg;
        i_a_imm      <= it.a_imm;
        i_b_is_reg   <= it.b_is_reg;
        i_b_reg      <= it.b_reg;
        i_b_imm      <= it.b_imm;
        i_c_is_reg   <= it.c_is_reg;
        i_c_reg      <= it.c_reg;
        i_c_imm      <= it.c_imm;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(it);
    endtask

    task automatic idle(int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding result has been seen
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // main sequence
    initial begin
        t_rf_item    it;
        bit          burst;
        int unsigned waited;
        sb    = new();
        burst = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the data
        send_item(write_op(8'd0, 32'h0));
        send_item(write_op(8'd255, 32'hFFFF_FFFF));
        send_item(write_op(8'd7, 32'h8000_0001));
        idle(2);
        send_item(read_op(8'd255));

        // every opcode once, invalid included
        for (int op = 0; op < 16; op++) begin
            send_item(exec_op(t_op'(op), 8'(16 + op), 1'b1, 8'd7, 32'h0,
                              1'b0, 8'd0, 32'd3, 1'b1, 8'd255, 32'h0));
            idle(op % 3);
        end

        // division and modulo by zero, wide shifts, max product, cmov false
        send_item(exec_op(OP_DIV, 8'd40, 1'b1, 8'd255, '0, 1'b0, '0, 32'h0, 1'b0, '0, '0));
        send_item(exec_op(OP_MOD, 8'd41, 1'b1, 8'd255, '0, 1'b1, 8'd0, '0, 1'b0, '0, '0));
        send_item(exec_op(OP_LSL, 8'd42, 1'b0, '0, 32'hFFFF_FFFF, 1'b0, '0, 32'd32,
                          1'b0, '0, '0));
        send_item(exec_op(OP_LSR, 8'd43, 1'b1, 8'd255, '0, 1'b0, '0, 32'hFFFF_FFFF,
                          1'b0, '0, '0));
        send_item(exec_op(OP_MUL, 8'd44, 1'b1, 8'd255, '0, 1'b1, 8'd255, '0, 1'b0, '0, '0));
        send_item(exec_op(OP_CMOV, 8'd45, 1'b1, 8'd0, '0, 1'b0, '0, 32'h1234,
                          1'b1, 8'd7, '0));
        // unknown kind changes nothing
        it      = random_item();
        it.kind = KIND_NONE;
        send_item(it);
        send_item(read_op(8'd40));
        drain_results();

        // random traffic with idle and back-to-back stretches
        for (int i = 0; i < 1650; i++) begin
            if (i % 150 == 0) burst = ($urandom_range(0, 2) == 0);
            if (i == 800) drain_results();
            send_item(random_item());
            if (!burst) idle(random_gap());
        end
        start <= 1'b0;

        // let the last results arrive, then a margin for stray strobes
        waited = 0;
        while (sb.pending() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
